// File: sv/sfs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sfs_pkg
// Shared widths, codes and types for the schedule frame slicer.
// ---------------------------------------------------------------------------
package sfs_pkg;

    localparam int TASK_W         = 16;
    localparam int TIME_W         = 32;
    localparam int SUM_W          = TIME_W + 1;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;
    localparam int MAX_SLICES_DEF = 64;

    // register index of frame_length (paddr[2])
    localparam logic REG_FRAME_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BACKWARDS = 2'd1,
        ST_TOO_LONG  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_WAIT,
        F_CHECK
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FIRST,
        B_BODY
    } back_state_t;

    // one classified task span, front to back
    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [TIME_W-1:0] dur;
        logic [SUM_W-1:0]  sum;
        logic              last;
        status_t           status;
    } job_t;

    // back end status seen by the front
    typedef struct packed {
        logic              idle;
        logic [TIME_W-1:0] fill;
    } back_stat_t;

endpackage : sfs_pkg
`default_nettype wire

// File: sv/sfs_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sfs_queue
// Two-entry job queue between the classifying front and the slicing back.
// ---------------------------------------------------------------------------
module sfs_queue
    import sfs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  job_t      push_job,
    output logic      q_ready,
    input  wire logic pop,
    output job_t      pop_job,
    output logic      q_valid
);

    job_t        mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign q_valid = (count_reg != 2'd0);
    assign q_ready = (count_reg != 2'd2);
    assign do_push = push && q_ready;
    assign do_pop  = pop && q_valid;
    assign pop_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != 2'd0)
        else $error("queue popped while empty");

endmodule : sfs_queue
`default_nettype wire

// File: sv/sfs_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sfs_front
// Accepts schedule entries, keeps the previous entry, derives the task span
// and classifies it (ok, backwards start, too many slices) into a job.
// ---------------------------------------------------------------------------
module sfs_front
    import sfs_pkg::*;
#(
    parameter int MAX_SLICES = MAX_SLICES_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [TASK_W-1:0] task_id,
    input  wire logic [TIME_W-1:0] entry_start,
    input  wire logic              last_entry,
    input  wire logic [TIME_W-1:0] frame_length,
    input  back_stat_t             back_stat,
    input  wire logic              q_valid,
    input  wire logic              q_ready,
    output logic                   push,
    output job_t                   push_job
);

    localparam int LIM_W = TIME_W + $clog2(MAX_SLICES);

    front_state_t      state_reg;
    front_state_t      state_next;
    logic [TASK_W-1:0] prev_task_reg;
    logic [TIME_W-1:0] prev_start_reg;
    logic              have_prev_reg;
    logic [TASK_W-1:0] cur_task_reg;
    logic [TIME_W-1:0] cur_start_reg;
    logic              cur_last_reg;
    logic              backwards_reg;
    logic [TIME_W-1:0] dur_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [LIM_W-1:0]  lim_reg;
    logic              accept;
    logic              drained;
    status_t           job_status;

    assign accept  = in_valid && in_ready;
    assign drained = back_stat.idle && !q_valid;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept && have_prev_reg)
                begin
                    state_next = F_WAIT;
                end
            end
            F_WAIT:
            begin
                if (drained)
                begin
                    state_next = F_CHECK;
                end
            end
            F_CHECK:
            begin
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        priority if (backwards_reg)
        begin
            job_status = ST_BACKWARDS;
        end
        else if (LIM_W'(sum_reg) > lim_reg)
        begin
            job_status = ST_TOO_LONG;
        end
        else
        begin
            job_status = ST_OK;
        end
        in_ready         = (state_reg == F_IDLE);
        push             = (state_reg == F_CHECK);
        push_job.task_id = prev_task_reg;
        push_job.dur     = dur_reg;
        push_job.sum     = sum_reg;
        push_job.last    = cur_last_reg;
        push_job.status  = job_status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            have_prev_reg  <= 1'b0;
            prev_task_reg  <= '0;
            prev_start_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && !have_prev_reg && !last_entry)
            begin
                prev_task_reg  <= task_id;
                prev_start_reg <= entry_start;
                have_prev_reg  <= 1'b1;
            end
            else if (push)
            begin
                if (cur_last_reg)
                begin
                    prev_task_reg  <= '0;
                    prev_start_reg <= '0;
                    have_prev_reg  <= 1'b0;
                end
                else if (job_status == ST_OK)
                begin
                    prev_task_reg  <= cur_task_reg;
                    prev_start_reg <= cur_start_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg <= LIM_W'(frame_length) * LIM_W'(MAX_SLICES - 1);
        if (accept)
        begin
            cur_task_reg  <= task_id;
            cur_start_reg <= entry_start;
            cur_last_reg  <= last_entry;
            backwards_reg <= (entry_start < prev_start_reg);
            dur_reg       <= entry_start - prev_start_reg;
        end
        // fill is final once the back has drained
        if (state_reg == F_WAIT && drained)
        begin
            sum_reg <= SUM_W'(back_stat.fill) + SUM_W'(dur_reg);
        end
    end

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> q_ready)
        else $error("job pushed into a full queue");

endmodule : sfs_front
`default_nettype wire

// File: sv/sfs_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sfs_back
// Cuts each job into frame slices, one slice per cycle while the output is free,
// into an output register, and keeps the fill of the open frame.
// ---------------------------------------------------------------------------
module sfs_back
    import sfs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [TIME_W-1:0] frame_length,
    input  wire logic              fill_clear,
    input  wire logic              q_valid,
    input  job_t                   pop_job,
    output logic                   pop,
    output back_stat_t             back_stat,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [TASK_W-1:0]      slice_task,
    output logic [TIME_W-1:0]      slice_length,
    output logic                   frame_end,
    output logic [1:0]             status,
    output logic                   run_last
);

    back_state_t       state_reg;
    back_state_t       state_next;
    job_t              job_reg;
    job_t              job_next;
    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  rem_next;
    logic [TIME_W-1:0] fill_reg;
    logic [TIME_W-1:0] fill_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [TASK_W-1:0] slice_task_reg;
    logic [TASK_W-1:0] slice_task_next;
    logic [TIME_W-1:0] slice_length_reg;
    logic [TIME_W-1:0] slice_length_next;
    logic              frame_end_reg;
    logic              frame_end_next;
    status_t           status_reg;
    status_t           status_next;
    logic              run_last_reg;
    logic              run_last_next;
    logic [SUM_W-1:0]  f_wide;
    logic              out_free;
    logic              sum_le;
    logic              sum_eq;
    logic              rem_ge;
    logic              rem_eq;

    assign f_wide   = SUM_W'(frame_length);
    assign out_free = !out_valid_reg || out_ready;
    assign sum_le   = (job_reg.sum <= f_wide);
    assign sum_eq   = (job_reg.sum == f_wide);
    assign rem_ge   = (rem_reg >= f_wide);
    assign rem_eq   = (rem_reg == f_wide);

    assign back_stat.idle = (state_reg == B_IDLE);
    assign back_stat.fill = fill_reg;

    assign out_valid    = out_valid_reg;
    assign slice_task   = slice_task_reg;
    assign slice_length = slice_length_reg;
    assign frame_end    = frame_end_reg;
    assign status       = status_reg;
    assign run_last     = run_last_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = B_FIRST;
                end
            end
            B_FIRST:
            begin
                if (out_free)
                begin
                    state_next = (job_reg.status != ST_OK || sum_le) ? B_IDLE : B_BODY;
                end
            end
            B_BODY:
            begin
                if (out_free && (!rem_ge || rem_eq))
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pop               = (state_reg == B_IDLE) && q_valid;
        job_next          = pop ? pop_job : job_reg;
        rem_next          = rem_reg;
        fill_next         = fill_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        slice_task_next   = slice_task_reg;
        slice_length_next = slice_length_reg;
        frame_end_next    = frame_end_reg;
        status_next       = status_reg;
        run_last_next     = run_last_reg;

        if (out_free && state_reg != B_IDLE)
        begin
            out_valid_next  = 1'b1;
            slice_task_next = job_reg.task_id;
            status_next     = ST_OK;
            unique case (state_reg)
                B_FIRST:
                begin
                    priority if (job_reg.status != ST_OK)
                    begin
                        slice_length_next = '0;
                        frame_end_next    = 1'b0;
                        status_next       = job_reg.status;
                        run_last_next     = 1'b1;
                        fill_next         = job_reg.last ? '0 : fill_reg;
                    end
                    else if (sum_le)
                    begin
                        slice_length_next = job_reg.dur;
                        frame_end_next    = sum_eq || job_reg.last;
                        run_last_next     = 1'b1;
                        fill_next         = (sum_eq || job_reg.last) ? '0
                                            : job_reg.sum[TIME_W-1:0];
                    end
                    else
                    begin
                        // close the open frame, carry the rest
                        slice_length_next = frame_length - fill_reg;
                        frame_end_next    = 1'b1;
                        run_last_next     = 1'b0;
                        rem_next          = job_reg.sum - f_wide;
                    end
                end
                B_BODY:
                begin
                    if (rem_ge)
                    begin
                        slice_length_next = frame_length;
                        frame_end_next    = 1'b1;
                        run_last_next     = rem_eq;
                        rem_next          = rem_reg - f_wide;
                        if (rem_eq)
                        begin
                            fill_next = '0;
                        end
                    end
                    else
                    begin
                        slice_length_next = rem_reg[TIME_W-1:0];
                        frame_end_next    = job_reg.last;
                        run_last_next     = 1'b1;
                        fill_next         = job_reg.last ? '0 : rem_reg[TIME_W-1:0];
                    end
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !out_ready;
                end
            endcase
        end

        if (fill_clear)
        begin
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg          <= job_next;
        rem_reg          <= rem_next;
        slice_task_reg   <= slice_task_next;
        slice_length_reg <= slice_length_next;
        frame_end_reg    <= frame_end_next;
        status_reg       <= status_next;
        run_last_reg     <= run_last_next;
    end

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |-> run_last_reg && slice_length_reg == '0)
        else $error("error result not a single empty slice");

    a_mid_slice_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !run_last_reg |-> frame_end_reg && status_reg == ST_OK)
        else $error("non-final slice does not close a frame");

    a_body_has_rest: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_BODY |-> rem_reg != '0 && job_reg.status == ST_OK)
        else $error("slicing loop entered with nothing left");

endmodule : sfs_back
`default_nettype wire

// File: sv/schedule_frame_slicer_top.sv
`default_nettype none
// Path: an entry that closes a task span passes F_WAIT and F_CHECK, the job queue
//   and B_FIRST before its first slice is registered; a first entry gives no result.
// Throughput: one slice per cycle out of the slicing loop while out_ready holds;
//   classification of an entry waits until the back end is idle and the queue
//   is empty, for the open frame fill left by the slicing of the entry before.
// Reset: rst_n clears the previous entry, the frame fill and frame_length to 1.
// ---------------------------------------------------------------------------
// schedule_frame_slicer_top
// Cuts schedule task spans into frame job slices; APB register frame_length.
// ---------------------------------------------------------------------------
module schedule_frame_slicer_top
    import sfs_pkg::*;
#(
    parameter int MAX_SLICES = MAX_SLICES_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [TASK_W-1:0] task_id,
    input  wire logic [TIME_W-1:0] entry_start,
    input  wire logic              last_entry,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [TASK_W-1:0]      slice_task,
    output logic [TIME_W-1:0]      slice_length,
    output logic                   frame_end,
    output logic [1:0]             status,
    output logic                   run_last
);

    logic [TIME_W-1:0] frame_length_reg;
    logic              reg_sel;
    logic              fl_write;
    logic              push;
    logic              pop;
    logic              q_valid;
    logic              q_ready;
    job_t              push_job;
    job_t              pop_job;
    back_stat_t        back_stat;

    assign pready   = 1'b1;
    assign reg_sel  = (paddr[2] == REG_FRAME_LENGTH);
    // drop writes of zero
    assign fl_write = psel && penable && pwrite && pready && reg_sel && (pwdata != '0);
    assign prdata   = reg_sel ? DATA_W'(frame_length_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= TIME_W'(1);
        end
        else if (fl_write)
        begin
            frame_length_reg <= pwdata[TIME_W-1:0];
        end
    end

    sfs_front #(
        .MAX_SLICES (MAX_SLICES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .task_id      (task_id),
        .entry_start  (entry_start),
        .last_entry   (last_entry),
        .frame_length (frame_length_reg),
        .back_stat    (back_stat),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .push         (push),
        .push_job     (push_job)
    );

    sfs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .q_ready  (q_ready),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_valid  (q_valid)
    );

    sfs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_length (frame_length_reg),
        .fill_clear   (fl_write),
        .q_valid      (q_valid),
        .pop_job      (pop_job),
        .pop          (pop),
        .back_stat    (back_stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .slice_task   (slice_task),
        .slice_length (slice_length),
        .frame_end    (frame_end),
        .status       (status),
        .run_last     (run_last)
    );

endmodule : schedule_frame_slicer_top
`default_nettype wire
